/* rtl/nch_pkg.sv */
// nch_pkg: shared widths, opcodes and payload types of the nearest center histogram.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package nch_pkg;

   localparam int COORD_BITS      = 16;
   localparam int COUNT_BITS      = 32;
   localparam int SLOT_BITS       = 6;
   localparam int CFG_BITS        = 7;
   localparam int DEF_MAX_CENTERS = 64;

   // squared gap of one axis, and the sum over three axes
   localparam int SQ_BITS   = 2 * COORD_BITS;
   localparam int DIST_BITS = SQ_BITS + 2;

   localparam logic [1:0] OP_LOAD     = 2'd0;
   localparam logic [1:0] OP_CLASSIFY = 2'd1;
   localparam logic [1:0] OP_READ     = 2'd2;

   typedef struct packed {
      logic [1:0]                   opcode;
      logic [SLOT_BITS-1:0]         slot;
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
      logic signed [COORD_BITS-1:0] coord_z;
   } req_payload_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0]  bin;
      logic [COUNT_BITS-1:0] hits;
   } rsp_payload_type;

   // travels alongside a center through the distance pipeline
   typedef struct packed {
      logic valid;
      logic last;
   } dist_tag_type;

endpackage : nch_pkg

`default_nettype wire

/* rtl/nearest_center_histogram_top.sv */
// nearest_center_histogram_top: center table, hit counters and scan sequencer.
// Depends on nch_pkg, nch_ram and nch_dist_unit.
//
// Usage
//  - Request channel (req_valid / req_stall / req_payload): one item is a load
//    (write one center), a classify (find the nearest center of a point and
//    bump its counter) or a read (return one counter). Opcode three reads.
//  - Response channel (rsp_valid / rsp_stall / rsp_payload): exactly one item
//    per request, in order: bin and the counter value after the step.
//  - csr_wr_en / csr_wr_data set how many leading centers a classify scans
//    (zero acts as one, values above MAX_CENTERS act as MAX_CENTERS).
//    Write only while the block is idle.
// Timing
//  - Classify walks the centers one per cycle through the distance pipeline
//    (center read, gap, square, sum).
//  - One item is in work at a time; req_stall is high until its response
//    sits in the output register.
// Reset
//  - After reset a clearing pass zeroes the counter memory, one entry per
//    cycle, with req_stall high. Centers are not cleared.
// Stall
//  - A stalled response holds in the output register. The next request is
//    taken meanwhile, but its response waits until that register frees up.
`timescale 1ns / 1ps
`default_nettype none

module nearest_center_histogram_top import nch_pkg::*; #(
   parameter int MAX_CENTERS = DEF_MAX_CENTERS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire req_payload_type     req_payload,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_payload_type          rsp_payload,
   input  wire logic                csr_wr_en,
   input  wire logic [CFG_BITS-1:0] csr_wr_data
);

   // index width, and a width that holds counts up to MAX_CENTERS and the register
   localparam int IW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
   localparam int NW = (IW + 1 > CFG_BITS) ? IW + 1 : CFG_BITS;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_CNT_RD = 3'd4;
   localparam logic [2:0] ST_CNT_WR = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [CFG_BITS-1:0]   n_use_ff;

   // per-item context
   logic                  is_cls_ff, is_cls_in;
   logic                  in_range_ff, in_range_in;
   logic [SLOT_BITS-1:0]  slot_ff, slot_in;
   logic [IW-1:0]         slot_idx_ff, slot_idx_in;
   logic [COORD_BITS-1:0] pt_x_ff, pt_y_ff, pt_z_ff;
   logic [COORD_BITS-1:0] pt_x_in, pt_y_in, pt_z_in;

   // scan control
   logic [IW-1:0]         scan_k_ff, scan_k_in;
   logic [IW-1:0]         last_k_ff, last_k_in;
   logic [IW-1:0]         cmp_k_ff, cmp_k_in;
   logic [IW-1:0]         best_ff, best_in;
   logic [DIST_BITS-1:0]  best_d_ff, best_d_in;
   logic [IW-1:0]         clr_addr_ff, clr_addr_in;
   dist_tag_type          issue_tag, issue_tag_ff, dist_tag;
   logic [DIST_BITS-1:0]  dist_val;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;

   logic                  accept, out_free;
   logic [NW-1:0]         n_lo, n_eff;

   // memory ports
   logic                  ctr_we;
   logic [COORD_BITS-1:0] ctr_x_rd, ctr_y_rd, ctr_z_rd;
   logic [COORD_BITS-1:0] ld_x, ld_y, ld_z;
   logic                  cnt_we;
   logic [IW-1:0]         cnt_waddr, cnt_raddr;
   logic [COUNT_BITS-1:0] cnt_wdata, cnt_rd, cnt_next;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // centers and points live in offset binary: sign bit flipped
   assign ld_x = {~req_payload.coord_x[COORD_BITS-1], req_payload.coord_x[COORD_BITS-2:0]};
   assign ld_y = {~req_payload.coord_y[COORD_BITS-1], req_payload.coord_y[COORD_BITS-2:0]};
   assign ld_z = {~req_payload.coord_z[COORD_BITS-1], req_payload.coord_z[COORD_BITS-2:0]};

   // effective center count, clamped to 1..MAX_CENTERS
   assign n_lo  = (n_use_ff == '0) ? NW'(1) : NW'(n_use_ff);
   assign n_eff = (n_lo > NW'(MAX_CENTERS)) ? NW'(MAX_CENTERS) : n_lo;

   assign in_range_in = (32'(req_payload.slot) < 32'(MAX_CENTERS));
   assign ctr_we      = accept && (req_payload.opcode == OP_LOAD) && in_range_in;

   // ---------------- center table ----------------
   nch_ram #(.DEPTH(MAX_CENTERS), .AW(IW), .DW(COORD_BITS)) u_ctr_x (
      .clock(clock), .wr_en(ctr_we), .wr_addr(IW'(req_payload.slot)), .wr_data(ld_x),
      .rd_addr(scan_k_ff), .rd_data(ctr_x_rd)
   );
   nch_ram #(.DEPTH(MAX_CENTERS), .AW(IW), .DW(COORD_BITS)) u_ctr_y (
      .clock(clock), .wr_en(ctr_we), .wr_addr(IW'(req_payload.slot)), .wr_data(ld_y),
      .rd_addr(scan_k_ff), .rd_data(ctr_y_rd)
   );
   nch_ram #(.DEPTH(MAX_CENTERS), .AW(IW), .DW(COORD_BITS)) u_ctr_z (
      .clock(clock), .wr_en(ctr_we), .wr_addr(IW'(req_payload.slot)), .wr_data(ld_z),
      .rd_addr(scan_k_ff), .rd_data(ctr_z_rd)
   );

   // ---------------- shared distance pipeline ----------------
   always_comb begin
      issue_tag.valid = (state_ff == ST_SCAN);
      issue_tag.last  = (state_ff == ST_SCAN) && (scan_k_ff == last_k_ff);
   end

   nch_dist_unit u_dist (
      .clock   (clock),
      .reset   (reset),
      .point_x (pt_x_ff),
      .point_y (pt_y_ff),
      .point_z (pt_z_ff),
      .center_x(ctr_x_rd),
      .center_y(ctr_y_rd),
      .center_z(ctr_z_rd),
      .tag_in  (issue_tag_ff),
      .dist_out(dist_val),
      .tag_out (dist_tag)
   );

   // ---------------- hit counters ----------------
   assign cnt_raddr = is_cls_ff ? best_ff : slot_idx_ff;
   assign cnt_next  = (cnt_rd == '1) ? cnt_rd : cnt_rd + COUNT_BITS'(1);

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         cnt_we    = 1'b1;
         cnt_waddr = clr_addr_ff;
         cnt_wdata = '0;
      end else begin
         cnt_we    = (state_ff == ST_CNT_WR) && out_free && is_cls_ff;
         cnt_waddr = best_ff;
         cnt_wdata = cnt_next;
      end
   end

   nch_ram #(.DEPTH(MAX_CENTERS), .AW(IW), .DW(COUNT_BITS)) u_cnt (
      .clock(clock), .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(cnt_wdata),
      .rd_addr(cnt_raddr), .rd_data(cnt_rd)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in       = state_ff;
      is_cls_in      = is_cls_ff;
      slot_in        = slot_ff;
      slot_idx_in    = slot_idx_ff;
      pt_x_in        = pt_x_ff;
      pt_y_in        = pt_y_ff;
      pt_z_in        = pt_z_ff;
      scan_k_in      = scan_k_ff;
      last_k_in      = last_k_ff;
      cmp_k_in       = cmp_k_ff;
      best_in        = best_ff;
      best_d_in      = best_d_ff;
      clr_addr_in    = clr_addr_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;

      // running minimum; strict less keeps the lowest index on a tie
      if (dist_tag.valid) begin
         if ((cmp_k_ff == '0) || (dist_val < best_d_ff)) begin
            best_in   = cmp_k_ff;
            best_d_in = dist_val;
         end
         cmp_k_in = cmp_k_ff + IW'(1);
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + IW'(1);
            if (clr_addr_ff == IW'(MAX_CENTERS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               is_cls_in   = (req_payload.opcode == OP_CLASSIFY);
               slot_in     = req_payload.slot;
               slot_idx_in = IW'(req_payload.slot);
               pt_x_in     = ld_x;
               pt_y_in     = ld_y;
               pt_z_in     = ld_z;
               scan_k_in   = '0;
               cmp_k_in    = '0;
               last_k_in   = IW'(n_eff - NW'(1));
               state_in    = (req_payload.opcode == OP_CLASSIFY) ? ST_SCAN : ST_CNT_RD;
            end
         end
         ST_SCAN: begin
            scan_k_in = scan_k_ff + IW'(1);
            if (scan_k_ff == last_k_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (dist_tag.valid && dist_tag.last) begin
               state_in = ST_CNT_RD;
            end
         end
         ST_CNT_RD: begin
            state_in = ST_CNT_WR;
         end
         ST_CNT_WR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (is_cls_ff) begin
                  rsp_payload_in.bin  = SLOT_BITS'(best_ff);
                  rsp_payload_in.hits = cnt_next;
               end else begin
                  rsp_payload_in.bin  = slot_ff;
                  rsp_payload_in.hits = in_range_ff ? cnt_rd : '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         n_use_ff     <= CFG_BITS'(1);
         rsp_valid_ff <= 1'b0;
         issue_tag_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_tag_ff <= issue_tag;
         if (csr_wr_en) begin
            n_use_ff <= csr_wr_data;
         end
      end
   end

   // item context and datapath
   always_ff @(posedge clock) begin
      is_cls_ff      <= is_cls_in;
      slot_ff        <= slot_in;
      slot_idx_ff    <= slot_idx_in;
      pt_x_ff        <= pt_x_in;
      pt_y_ff        <= pt_y_in;
      pt_z_ff        <= pt_z_in;
      scan_k_ff      <= scan_k_in;
      last_k_ff      <= last_k_in;
      cmp_k_ff       <= cmp_k_in;
      best_ff        <= best_in;
      best_d_ff      <= best_d_in;
      rsp_payload_ff <= rsp_payload_in;
      if (accept) begin
         in_range_ff <= in_range_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule : nearest_center_histogram_top

`default_nettype wire

/* rtl/nch_ram.sv */
// nch_ram: single write port, single registered read port memory.
// Holds center coordinates and hit counters; uses nch_pkg for defaults.
`timescale 1ns / 1ps
`default_nettype none

module nch_ram import nch_pkg::*; #(
   parameter int DEPTH = DEF_MAX_CENTERS,
   parameter int AW    = 6,
   parameter int DW    = COUNT_BITS
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : nch_ram

`default_nettype wire

/* rtl/nch_dist_unit.sv */
// nch_dist_unit: three-stage squared Euclidean distance pipeline (gap, square, sum).
// Takes biased coordinates; uses nch_pkg for widths and the tag type.
`timescale 1ns / 1ps
`default_nettype none

module nch_dist_unit import nch_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [COORD_BITS-1:0] point_x,
   input  wire logic [COORD_BITS-1:0] point_y,
   input  wire logic [COORD_BITS-1:0] point_z,
   input  wire logic [COORD_BITS-1:0] center_x,
   input  wire logic [COORD_BITS-1:0] center_y,
   input  wire logic [COORD_BITS-1:0] center_z,
   input  wire dist_tag_type          tag_in,
   output logic      [DIST_BITS-1:0]  dist_out,
   output dist_tag_type               tag_out
);

   logic [COORD_BITS-1:0] gap_x_in, gap_y_in, gap_z_in;
   logic [COORD_BITS-1:0] gap_x_ff, gap_y_ff, gap_z_ff;
   logic [SQ_BITS-1:0]    sq_x_in, sq_y_in, sq_z_in;
   logic [SQ_BITS-1:0]    sq_x_ff, sq_y_ff, sq_z_ff;
   logic [DIST_BITS-1:0]  sum_in, sum_ff;
   dist_tag_type          tag1_ff, tag2_ff, tag3_ff;

   // offset-binary keeps order, so an unsigned abs gap is exact
   assign gap_x_in = (point_x > center_x) ? point_x - center_x : center_x - point_x;
   assign gap_y_in = (point_y > center_y) ? point_y - center_y : center_y - point_y;
   assign gap_z_in = (point_z > center_z) ? point_z - center_z : center_z - point_z;

   assign sq_x_in = SQ_BITS'(gap_x_ff) * SQ_BITS'(gap_x_ff);
   assign sq_y_in = SQ_BITS'(gap_y_ff) * SQ_BITS'(gap_y_ff);
   assign sq_z_in = SQ_BITS'(gap_z_ff) * SQ_BITS'(gap_z_ff);

   assign sum_in = DIST_BITS'(sq_x_ff) + DIST_BITS'(sq_y_ff) + DIST_BITS'(sq_z_ff);

   always_ff @(posedge clock) begin
      gap_x_ff <= gap_x_in;
      gap_y_ff <= gap_y_in;
      gap_z_ff <= gap_z_in;
      sq_x_ff  <= sq_x_in;
      sq_y_ff  <= sq_y_in;
      sq_z_ff  <= sq_z_in;
      sum_ff   <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= tag_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   assign dist_out = sum_ff;
   assign tag_out  = tag3_ff;

endmodule : nch_dist_unit

`default_nettype wire
